### design/text_console_writer_assert.svh
// Assertion macros shared by the text console checker.
// Expects clk and rst to be visible where the macros are used.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TCW_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("text console check failed");

// Next-cycle implication, disabled while reset is high.
`define TCW_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("text console check failed");

`endif

### design/tcw_pkg.sv
// Shared types and constants of the text console writer.
// No dependencies; the front end, queue, back end and top level import this package.
`timescale 1ns / 1ps

package tcw_pkg;

  // Command codes of a request item.
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Control characters.
  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_CR = 8'd13;

  // Reset value of the attribute register.
  localparam logic [7:0] ATTR_RESET = 8'h07;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        scrolled;
  } rsp_t;

  // Operation classes decided by the front end.
  typedef enum logic [2:0] {
    OP_PRINT,
    OP_LF,
    OP_CR,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_kind_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  code;
    logic [7:0]  attr;
    logic [10:0] index;
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCROLL,
    ST_READ
  } state_t;

endpackage

### design/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/tcw_front.sv
// Front end: holds the attribute register, accepts request items and
// classifies them into queue entries. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tcw_pkg::req_t req,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  input  logic          q_full,
  input  logic          init_busy,
  output logic          push,
  output tcw_pkg::op_t  op
);
  import tcw_pkg::*;

  logic [7:0] attr;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_we) begin
      attr <= cfg_wdata;
    end
  end

  assign req_stall = q_full || init_busy;
  assign push      = req_valid && !req_stall;

  always_comb begin
    op.code  = req.char_code;
    op.attr  = attr;
    op.index = req.cell_index;
    case (req.cmd)
      CMD_PUT: begin
        if (req.char_code == CHAR_LF) begin
          op.kind = OP_LF;
        end else if (req.char_code == CHAR_CR) begin
          op.kind = OP_CR;
        end else begin
          op.kind = OP_PRINT;
        end
      end
      CMD_CLEAR: op.kind = OP_CLEAR;
      CMD_READ:  op.kind = OP_READ;
      default:   op.kind = OP_NOP;
    endcase
  end

endmodule

### design/tcw_queue.sv
// Two-entry queue of classified operations between front and back end.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  tcw_pkg::op_t push_op,
  input  logic         pop,
  output logic         full,
  output logic         not_empty,
  output tcw_pkg::op_t head
);
  import tcw_pkg::*;

  op_t        entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### design/tcw_back.sv
// Back end: cursor, screen memory, scroll and clear sweeps, result register.
// Depends on tcw_pkg and tcw_ram.
`timescale 1ns / 1ps

module tcw_back #(
  parameter int NUM_COLUMNS = 80,
  parameter int NUM_ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  input  tcw_pkg::op_t  op,
  output logic          op_pop,
  output logic          init_busy,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output tcw_pkg::rsp_t rsp
);
  import tcw_pkg::*;

  localparam int CELLS  = NUM_COLUMNS * NUM_ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(NUM_COLUMNS);
  localparam int ROW_W  = $clog2(NUM_ROWS);

  state_t           state, state_next;
  logic [COL_W-1:0] col, col_next;
  logic [ROW_W-1:0] row, row_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             done_rsp, done_rsp_next;
  logic             rd_ok, rd_ok_next;
  logic             rsp_valid_next;
  rsp_t             rsp_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;

  logic              emit;
  logic              emit_scrolled;
  logic [15:0]       emit_data;
  logic              out_free;
  logic              last_col;
  logic              last_row;
  logic [ADDR_W-1:0] pos;
  logic [CNT_W-1:0]  cnt_m1;

  function automatic rsp_t make_rsp(logic [15:0] data, logic [COL_W-1:0] c,
                                    logic [ROW_W-1:0] r, logic s);
    rsp_t x;
    x.cell_data  = data;
    x.cursor_col = 7'(c);
    x.cursor_row = 5'(r);
    x.scrolled   = s;
    return x;
  endfunction

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign init_busy = (state == ST_CLEAR) && !done_rsp;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign last_col  = (col == COL_W'(NUM_COLUMNS - 1));
  assign last_row  = (row == ROW_W'(NUM_ROWS - 1));
  assign pos       = ADDR_W'(int'(row) * NUM_COLUMNS + int'(col));
  assign cnt_m1    = cnt - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      col       <= '0;
      row       <= '0;
      cnt       <= '0;
      done_rsp  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      col       <= col_next;
      row       <= row_next;
      cnt       <= cnt_next;
      done_rsp  <= done_rsp_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp   <= rsp_next;
    rd_ok <= rd_ok_next;
  end

  always_comb begin
    state_next     = state;
    col_next       = col;
    row_next       = row;
    cnt_next       = cnt;
    done_rsp_next  = done_rsp;
    rd_ok_next     = rd_ok;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    op_pop         = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;
    emit           = 1'b0;
    emit_scrolled  = 1'b0;
    emit_data      = '0;

    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[ADDR_W-1:0];
        if (cnt == CNT_W'(CELLS - 1)) begin
          cnt_next      = '0;
          state_next    = ST_IDLE;
          emit          = done_rsp;
          done_rsp_next = 1'b0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      ST_IDLE: begin
        if (op_valid && out_free) begin
          op_pop = 1'b1;
          case (op.kind)
            OP_PRINT: begin
              ram_we    = 1'b1;
              ram_waddr = pos;
              ram_wdata = {op.attr, op.code};
              if (!last_col) begin
                col_next = col + 1'b1;
                emit     = 1'b1;
              end else if (!last_row) begin
                col_next = '0;
                row_next = row + 1'b1;
                emit     = 1'b1;
              end else begin
                col_next   = '0;
                cnt_next   = '0;
                state_next = ST_SCROLL;
              end
            end
            OP_LF: begin
              col_next = '0;
              if (!last_row) begin
                row_next = row + 1'b1;
                emit     = 1'b1;
              end else begin
                cnt_next   = '0;
                state_next = ST_SCROLL;
              end
            end
            OP_CR: begin
              col_next = '0;
              emit     = 1'b1;
            end
            OP_CLEAR: begin
              col_next      = '0;
              row_next      = '0;
              cnt_next      = '0;
              done_rsp_next = 1'b1;
              state_next    = ST_CLEAR;
            end
            OP_READ: begin
              ram_raddr  = ADDR_W'(op.index);
              rd_ok_next = (32'(op.index) < 32'(CELLS));
              state_next = ST_READ;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      ST_SCROLL: begin
        // Read one row ahead, write the cell one step behind; the last row
        // is written with blanks.
        if (cnt < CNT_W'(CELLS - NUM_COLUMNS)) begin
          ram_raddr = cnt[ADDR_W-1:0] + ADDR_W'(NUM_COLUMNS);
        end
        if (cnt != '0) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_m1[ADDR_W-1:0];
          ram_wdata = (cnt_m1 < CNT_W'(CELLS - NUM_COLUMNS)) ? ram_rdata : 16'h0000;
        end
        if (cnt == CNT_W'(CELLS)) begin
          cnt_next      = '0;
          state_next    = ST_IDLE;
          emit          = 1'b1;
          emit_scrolled = 1'b1;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      ST_READ: begin
        emit       = 1'b1;
        emit_data  = rd_ok ? ram_rdata : 16'h0000;
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (emit) begin
      rsp_valid_next = 1'b1;
      rsp_next       = make_rsp(emit_data, col_next, row_next, emit_scrolled);
    end
  end

endmodule

### design/text_console_writer.sv
// Top level of the text console writer: front end, operation queue, back end.
// Depends on tcw_pkg, tcw_front, tcw_queue, tcw_back and tcw_ram.
//
//   Channel   Handshake              Payload
//   request   req_valid / req_stall  req (cmd, char_code, cell_index)
//   result    rsp_valid / rsp_stall  rsp (cell_data, cursor_col, cursor_row, scrolled)
//   config    cfg_we                 cfg_wdata (text attribute)
//
// A print, line feed, carriage return or unused command is handled in the idle state alone.
// A read passes through the idle and read states, since the screen memory has a registered read port.
// A scroll follows its print or line feed with a sweep over the whole screen
// memory; a clear is followed by a sweep that blanks every cell of the
// screen. Both are limited by the single write port.
// After reset the screen is zeroed with req_stall high.
// The two-entry queue keeps taking items while the back end is busy or rsp is stalled, until it is full.
`timescale 1ns / 1ps

module text_console_writer #(
  parameter int NUM_COLUMNS = 80,
  parameter int NUM_ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tcw_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output tcw_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata
);
  import tcw_pkg::*;

  // Classified item from the front end and the queue head seen by the back end.
  op_t  front_op;
  op_t  head_op;
  logic push;
  logic pop;
  logic q_full;
  logic q_not_empty;
  // High during the post-reset clearing pass, when no item may be accepted.
  logic init_busy;

  tcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .init_busy (init_busy),
    .push      (push),
    .op        (front_op)
  );

  // The queue decouples acceptance from execution so that a long sweep
  // in the back end does not immediately stall the request side.
  tcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (front_op),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_op)
  );

  // The back end owns the cursor, the screen memory and the result register.
  tcw_back #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_ROWS    (NUM_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (q_not_empty),
    .op        (head_op),
    .op_pop    (pop),
    .init_busy (init_busy),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

### design/tcw_checker.sv
// Port-level checker of the text console writer and its bind to the top level.
// Depends on tcw_pkg and text_console_writer_assert.svh.
`timescale 1ns / 1ps
`include "text_console_writer_assert.svh"

module tcw_checker #(
  parameter int NUM_ROWS = 25
) (
  input logic          clk,
  input logic          rst,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input tcw_pkg::rsp_t rsp
);

  // A scrolling result leaves the cursor at the start of the bottom row.
  logic scroll_home;

  assign scroll_home = (rsp.cursor_col == 7'd0) && (rsp.cursor_row == 5'(NUM_ROWS - 1));

  `TCW_ASSERT_NEXT(a_rsp_valid_hold, rsp_valid && rsp_stall, rsp_valid)
  `TCW_ASSERT_NEXT(a_rsp_payload_hold, rsp_valid && rsp_stall, $stable(rsp))
  `TCW_ASSERT_NOW(a_scroll_cursor, rsp_valid && rsp.scrolled, scroll_home)
  `TCW_ASSERT_NOW(a_init_stall, $past(rst), req_stall)

endmodule

bind text_console_writer tcw_checker #(
  .NUM_ROWS (NUM_ROWS)
) u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

### sim/text_console_writer_test.sv
// Self-checking testbench for the text console writer: put, clear and read items.
// A built-in screen and cursor predictor checks every result; depends on tcw_pkg.
`timescale 1ns / 1ps

module text_console_writer_test;
  import tcw_pkg::*;

  // Screen geometry, matching the parameters given to the instance below.
  localparam int NUM_COLUMNS = 80;
  localparam int NUM_ROWS    = 25;
  localparam int NUM_CELLS   = NUM_COLUMNS * NUM_ROWS;

  // The package names three commands; the fourth code does nothing.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // A scroll or a clear sweeps the whole screen memory, so that is the
  // longest the block can stay busy after its last result has gone out.
  localparam int SETTLE_CYCLES  = NUM_CELLS + 100;
  // Cycles with no handshake at all before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int PHASE_ITEMS    = 285;

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req       = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;
  logic  cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;

  // Items waiting to be driven, and the results the console should return,
  // oldest first.
  req_t request_backlog[$];
  rsp_t console_replies[$];

  // Predicted console state.
  logic [15:0] screen_model [NUM_CELLS];
  logic [6:0]  cursor_col_m;
  logic [4:0]  cursor_row_m;
  logic [7:0]  text_attr_m;

  // Idle and stall rates of the current phase, in percent.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Set at each rising edge when the request on the bus was taken there.
  logic req_taken = 1'b0;
  int   idle_cycles = 0;

  int mismatch_count = 0;
  int items_taken    = 0;
  int results_seen   = 0;
  int read_count     = 0;
  int scroll_count   = 0;
  int clear_count    = 0;
  int attr_writes    = 0;

  text_console_writer #(
    .NUM_COLUMNS(NUM_COLUMNS),
    .NUM_ROWS   (NUM_ROWS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Moves the cursor to the start of the next line. When it runs off the
  // bottom, every row moves up by one and the bottom row is blanked.
  // Returns 1 when the screen scrolled.
  function automatic logic start_new_line();
    cursor_col_m = '0;
    cursor_row_m = cursor_row_m + 5'd1;
    if (cursor_row_m < NUM_ROWS) return 1'b0;
    cursor_row_m = 5'(NUM_ROWS - 1);
    for (int i = 0; i < NUM_CELLS - NUM_COLUMNS; i++)
      screen_model[i] = screen_model[i + NUM_COLUMNS];
    for (int i = NUM_CELLS - NUM_COLUMNS; i < NUM_CELLS; i++)
      screen_model[i] = '0;
    scroll_count++;
    return 1'b1;
  endfunction

  function automatic void blank_screen();
    foreach (screen_model[i]) screen_model[i] = '0;
    cursor_col_m = '0;
    cursor_row_m = '0;
  endfunction

  // Applies one accepted item to the predicted console and returns the
  // result the block must report for it.
  function automatic rsp_t console_update(req_t item);
    rsp_t reply;
    reply = '0;
    case (item.cmd)
      CMD_PUT: begin
        if (item.char_code == CHAR_LF) begin
          reply.scrolled = start_new_line();
        end else if (item.char_code == CHAR_CR) begin
          cursor_col_m = '0;
        end else begin
          // The character lands under the cursor with the current attribute.
          // A print in the last column wraps the line right away.
          screen_model[cursor_row_m * NUM_COLUMNS + cursor_col_m] =
            {text_attr_m, item.char_code};
          cursor_col_m = cursor_col_m + 7'd1;
          if (cursor_col_m >= NUM_COLUMNS) reply.scrolled = start_new_line();
        end
      end
      CMD_CLEAR: begin
        blank_screen();
        clear_count++;
      end
      CMD_READ: begin
        // Indexes past the end of the screen read as zero.
        if (item.cell_index < NUM_CELLS) reply.cell_data = screen_model[item.cell_index];
        read_count++;
      end
      default: ;
    endcase
    reply.cursor_col = cursor_col_m;
    reply.cursor_row = cursor_row_m;
    return reply;
  endfunction

  task automatic compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Driver. The request bus changes only at falling edges. A new item goes
  // out once the previous one was taken, unless the sender decides to idle;
  // a stalled item stays on the bus unchanged.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req       <= request_backlog.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor. At each rising edge it records attribute writes, predicts the
  // result of each accepted item and checks each accepted result against
  // the oldest prediction.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      req_taken   <= 1'b0;
      idle_cycles <= 0;
      blank_screen();
      text_attr_m = ATTR_RESET;
    end else begin
      req_taken <= req_valid && !req_stall;
      if (cfg_we) begin
        text_attr_m = cfg_wdata;
        attr_writes++;
      end
      if (req_valid && !req_stall) begin
        console_replies.push_back(console_update(req));
        items_taken++;
      end
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (console_replies.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result with nothing outstanding, expected none, actual %h",
                   $time, rsp);
        end else begin
          want = console_replies.pop_front();
          compare_field("cell_data",  want.cell_data,  rsp.cell_data);
          compare_field("cursor_col", want.cursor_col, rsp.cursor_col);
          compare_field("cursor_row", want.cursor_row, rsp.cursor_row);
          compare_field("scrolled",   want.scrolled,   rsp.scrolled);
        end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: a long stretch with no handshake means the block is stuck.
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic queue_request(logic [1:0] cmd, logic [7:0] code, logic [10:0] index);
    req_t item;
    item.cmd        = cmd;
    item.char_code  = code;
    item.cell_index = index;
    request_backlog.push_back(item);
  endtask

  // Any byte other than the two control characters.
  function automatic logic [7:0] printable_code();
    logic [7:0] code;
    do code = 8'($urandom_range(255));
    while (code == CHAR_LF || code == CHAR_CR);
    return code;
  endfunction

  // Waits until every item has been sent and answered, then lets a full
  // screen sweep go by so that no scroll is still running in the back end.
  task automatic settle();
    while (request_backlog.size() != 0 || req_valid || console_replies.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_attribute(logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic. Most of it is plain prints and reads; about one pick in
  // ten is a whole text line ending in carriage return and line feed, which
  // together with loose line feeds drives the cursor to the bottom row so
  // that scrolling and last-column wraps happen often. Clears are rare,
  // since each one sends the cursor back to the top.
  task automatic add_random_traffic(int count);
    int made;
    int pick;
    int len;
    logic [10:0] index;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(999);
      if (pick < 100) begin
        len = $urandom_range(85, 1);
        repeat (len) queue_request(CMD_PUT, printable_code(), 11'($urandom));
        queue_request(CMD_PUT, CHAR_CR, 11'($urandom));
        queue_request(CMD_PUT, CHAR_LF, 11'($urandom));
        made += len + 2;
      end else begin
        if (pick < 600) begin
          queue_request(CMD_PUT, 8'($urandom), 11'($urandom));
        end else if (pick < 690) begin
          queue_request(CMD_PUT, CHAR_LF, 11'($urandom));
        end else if (pick < 720) begin
          queue_request(CMD_PUT, CHAR_CR, 11'($urandom));
        end else if (pick < 940) begin
          if ($urandom_range(9) == 0) index = 11'($urandom_range(2047, NUM_CELLS));
          else index = 11'($urandom_range(NUM_CELLS - 1));
          queue_request(CMD_READ, 8'($urandom), index);
        end else if (pick < 995) begin
          queue_request(CMD_UNUSED, 8'($urandom), 11'($urandom));
        end else begin
          queue_request(CMD_CLEAR, 8'($urandom), 11'($urandom));
        end
        made++;
      end
    end
  endtask

  task automatic run_phase(logic [7:0] attr, int idle_pct, int stall_pct);
    settle();
    write_attribute(attr);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    add_random_traffic(PHASE_ITEMS);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed part, with the reset attribute. Reads of a blank screen,
    // including the last cell and indexes past the end of the screen.
    queue_request(CMD_READ, 8'h00, 11'd0);
    queue_request(CMD_READ, 8'h00, 11'(NUM_CELLS - 1));
    queue_request(CMD_READ, 8'h00, 11'(NUM_CELLS));
    queue_request(CMD_READ, 8'hFF, 11'h7FF);
    // Prints with the extremes of the character byte, then read them back.
    queue_request(CMD_PUT, 8'h41, 11'd0);
    queue_request(CMD_PUT, 8'hFF, 11'h7FF);
    queue_request(CMD_PUT, 8'h00, 11'd0);
    queue_request(CMD_READ, 8'h00, 11'd0);
    queue_request(CMD_READ, 8'h00, 11'd1);
    queue_request(CMD_READ, 8'h00, 11'd2);
    // Carriage return goes back to column 0, so the next print overwrites
    // the first cell; line feed then moves to the next row.
    queue_request(CMD_PUT, CHAR_CR, 11'd0);
    queue_request(CMD_PUT, 8'h42, 11'd0);
    queue_request(CMD_PUT, CHAR_LF, 11'd0);
    // The unused command must leave everything alone.
    queue_request(CMD_UNUSED, 8'hFF, 11'h7FF);
    queue_request(CMD_READ, 8'h00, 11'd0);
    // Clear wipes the screen and homes the cursor.
    queue_request(CMD_CLEAR, 8'h00, 11'd0);
    queue_request(CMD_READ, 8'h00, 11'd0);
    queue_request(CMD_READ, 8'h00, 11'd2);

    // A zero attribute leaves only the character byte in the cell.
    settle();
    write_attribute(8'h00);
    queue_request(CMD_PUT, 8'h5A, 11'd0);
    queue_request(CMD_READ, 8'h00, 11'd0);

    // Random phases, each with its own attribute and handshake pressure.
    run_phase(8'hFF, 0, 0);
    run_phase(8'($urandom_range(255)), 77, 0);
    run_phase(8'($urandom_range(255)), 0, 77);
    run_phase(8'($urandom_range(255)), 26, 26);
    settle();

    $display("Covered %0d items and %0d results: %0d reads, %0d scrolls, %0d clears,",
             items_taken, results_seen, read_count, scroll_count, clear_count);
    $display("%0d attribute settings and four handshake pressure phases.", attr_writes);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
